// ----- rtl/core/fat_chain_and_inode_allocator_core_defines.svh -----
// Assertion macros shared by the allocator RTL.
`ifndef FAT_CHAIN_AND_INODE_ALLOCATOR_CORE_DEFINES_SVH
`define FAT_CHAIN_AND_INODE_ALLOCATOR_CORE_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define FCIA_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define FCIA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/fcia_pkg.sv -----
// Package with the types, constants and codes of the allocator.
package fcia_pkg;

    localparam int TABLE_ENTRIES     = 512;
    localparam int RESERVED_CLUSTERS = 18;
    localparam int CLUSTER_BYTES     = 1024;
    localparam int MAP_ROWS          = 32;
    localparam int ROW_BITS          = 16;

    localparam logic [15:0] END_MARK = 16'hffff;

    localparam int CL_AW       = $clog2(TABLE_ENTRIES);
    localparam int ROW_AW      = (MAP_ROWS > 1) ? $clog2(MAP_ROWS) : 1;
    localparam int CLR_LEN     = (MAP_ROWS > TABLE_ENTRIES) ? MAP_ROWS : TABLE_ENTRIES;
    localparam int IDX_W       = $clog2(CLR_LEN + 1);
    localparam int CNT_W       = 10;
    localparam int BYTE_SHIFT  = $clog2(CLUSTER_BYTES);
    localparam int NEED_W      = 17 - BYTE_SHIFT;
    localparam int CLUSTER_MAX = TABLE_ENTRIES - RESERVED_CLUSTERS;
    localparam int INODE_MAX   = MAP_ROWS * ROW_BITS;

    localparam logic [1:0] KIND_CREATE  = 2'd0;
    localparam logic [1:0] KIND_EXTEND  = 2'd1;
    localparam logic [1:0] KIND_RELEASE = 2'd2;
    localparam logic [1:0] KIND_READ    = 2'd3;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_NOSPACE  = 2'd1;
    localparam logic [1:0] STAT_NOINODE  = 2'd2;
    localparam logic [1:0] STAT_NOTUSED  = 2'd3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [8:0]  cluster;
        logic [15:0] byte_count;
        logic [8:0]  inode_number;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] result_cluster;
        logic [8:0]  new_inode;
        logic [9:0]  clusters_changed;
        logic [9:0]  free_clusters;
        logic [9:0]  free_inodes;
    } rsp_t;

endpackage

// ----- rtl/core/fcia_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
module fcia_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 512
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/core/fat_chain_and_inode_allocator_core.sv -----
// Top level of the FAT cluster chain and inode allocator.
//
//   Channel | Direction | Handshake         | Payload
//   --------+-----------+-------------------+------------------------------
//   req     | in        | req_valid/stall   | req_t: kind, cluster, bytes, inode
//   rsp     | out       | rsp_valid/stall   | rsp_t: status, cluster, counts
//
// One item is worked on at a time by a sequencer around the cluster table RAM.
// Create scans the table for a free entry, then the inode bitmap rows. Extend
// counts free entries in one table scan, walks the chain, then allocates in a
// second scan. Release walks the chain and frees each link. Read is one table read.
// After reset a clearing pass over max(N, ROWS) entries (N the table depth)
// initializes both RAMs, and the block holds req_stall high during it. A stalled
// result sits in the output register while the next item is already accepted.
module fat_chain_and_inode_allocator_core
    import fcia_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    `include "fat_chain_and_inode_allocator_core_defines.svh"

    // Sequencer states.
    localparam logic [4:0] S_CLR     = 5'd0;
    localparam logic [4:0] S_IDLE    = 5'd1;
    localparam logic [4:0] S_C_SCAN  = 5'd2;
    localparam logic [4:0] S_C_IA    = 5'd3;
    localparam logic [4:0] S_C_IB    = 5'd4;
    localparam logic [4:0] S_C_WR    = 5'd5;
    localparam logic [4:0] S_E_CHK0  = 5'd6;
    localparam logic [4:0] S_E_CNT   = 5'd7;
    localparam logic [4:0] S_E_WA    = 5'd8;
    localparam logic [4:0] S_E_WB    = 5'd9;
    localparam logic [4:0] S_E_ALLOC = 5'd10;
    localparam logic [4:0] S_E_FIN   = 5'd11;
    localparam logic [4:0] S_R_CHK   = 5'd12;
    localparam logic [4:0] S_R_A     = 5'd13;
    localparam logic [4:0] S_R_B     = 5'd14;
    localparam logic [4:0] S_R_FIN   = 5'd15;
    localparam logic [4:0] S_RD      = 5'd16;
    localparam logic [4:0] S_DONE    = 5'd17;

    // Lowest clear bit of an inode bitmap row.
    function automatic logic [3:0] low_zero(input logic [15:0] d);
        logic [3:0] pos;
        pos = 4'd0;
        for (int i = 15; i >= 0; i--)
        begin
            if (!d[i])
            begin
                pos = 4'(i);
            end
        end
        return pos;
    endfunction

    logic [4:0]        state_reg, state_next;
    req_t              op_reg, op_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic              pv_reg, pv_next;
    logic [CL_AW-1:0]  pa_reg, pa_next;
    logic [CL_AW-1:0]  cur_reg, cur_next;
    logic [15:0]       v_reg, v_next;
    logic [IDX_W-1:0]  steps_reg, steps_next;
    logic [CL_AW-1:0]  last_reg, last_next;
    logic [NEED_W-1:0] need_reg, need_next;
    logic [NEED_W-1:0] left_reg, left_next;
    logic [IDX_W-1:0]  tally_reg, tally_next;
    logic [CL_AW-1:0]  fc_reg, fc_next;
    logic [ROW_AW-1:0] row_reg, row_next;
    logic [3:0]        bit_reg, bit_next;
    logic [15:0]       rowd_reg, rowd_next;
    logic [CNT_W-1:0]  fcnt_reg, fcnt_next;
    logic [CNT_W-1:0]  icnt_reg, icnt_next;
    logic [1:0]        stat_reg, stat_next;
    logic [15:0]       res_reg, res_next;
    logic [8:0]        nino_reg, nino_next;
    logic [9:0]        chg_reg, chg_next;
    rsp_t              out_reg, out_next;
    logic              out_v_reg, out_v_next;

    logic              tbl_we;
    logic [CL_AW-1:0]  tbl_waddr, tbl_raddr;
    logic [15:0]       tbl_wdata, tbl_rdata;
    logic              ino_we;
    logic [ROW_AW-1:0] ino_waddr, ino_raddr;
    logic [15:0]       ino_wdata, ino_rdata;

    logic [16:0]       need_sum;
    logic              scan_end;
    logic [IDX_W:0]    fsum;

    fcia_ram #(.WIDTH(16), .DEPTH(TABLE_ENTRIES)) u_table (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (tbl_wdata),
        .raddr (tbl_raddr),
        .rdata (tbl_rdata)
    );

    fcia_ram #(.WIDTH(16), .DEPTH(MAP_ROWS)) u_imap (
        .clk   (clk),
        .we    (ino_we),
        .waddr (ino_waddr),
        .wdata (ino_wdata),
        .raddr (ino_raddr),
        .rdata (ino_rdata)
    );

    assign need_sum  = {1'b0, req.byte_count} + 17'(CLUSTER_BYTES - 1);
    assign scan_end  = !pv_reg && (idx_reg >= IDX_W'(TABLE_ENTRIES));
    assign fsum      = (IDX_W + 1)'(fcnt_reg) + (IDX_W + 1)'(tally_reg);
    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = out_v_reg;
    assign rsp       = out_reg;

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        idx_next   = idx_reg;
        pv_next    = pv_reg;
        pa_next    = pa_reg;
        cur_next   = cur_reg;
        v_next     = v_reg;
        steps_next = steps_reg;
        last_next  = last_reg;
        need_next  = need_reg;
        left_next  = left_reg;
        tally_next = tally_reg;
        fc_next    = fc_reg;
        row_next   = row_reg;
        bit_next   = bit_reg;
        rowd_next  = rowd_reg;
        fcnt_next  = fcnt_reg;
        icnt_next  = icnt_reg;
        stat_next  = stat_reg;
        res_next   = res_reg;
        nino_next  = nino_reg;
        chg_next   = chg_reg;
        out_next   = out_reg;
        out_v_next = out_v_reg && rsp_stall;
        tbl_we     = 1'b0;
        tbl_waddr  = cur_reg;
        tbl_wdata  = 16'd0;
        tbl_raddr  = CL_AW'(req.cluster);
        ino_we     = 1'b0;
        ino_waddr  = row_reg;
        ino_wdata  = 16'd0;
        ino_raddr  = ROW_AW'(req.inode_number >> 4);

        // The scan states walk the table from entry 1 with one read per cycle;
        // the data for the entry issued last cycle is checked this cycle.
        if ((state_reg == S_C_SCAN) || (state_reg == S_E_CNT) || (state_reg == S_E_ALLOC))
        begin
            if (idx_reg < IDX_W'(TABLE_ENTRIES))
            begin
                tbl_raddr = idx_reg[CL_AW-1:0];
                pv_next   = 1'b1;
                pa_next   = idx_reg[CL_AW-1:0];
                idx_next  = idx_reg + 1'b1;
            end
            else
            begin
                pv_next = 1'b0;
            end
        end

        unique case (state_reg)
            S_CLR:
            begin
                tbl_we    = (idx_reg < IDX_W'(TABLE_ENTRIES));
                tbl_waddr = idx_reg[CL_AW-1:0];
                tbl_wdata = (idx_reg < IDX_W'(RESERVED_CLUSTERS)) ? END_MARK : 16'd0;
                ino_we    = (idx_reg < IDX_W'(MAP_ROWS));
                ino_waddr = ROW_AW'(idx_reg);
                idx_next  = idx_reg + 1'b1;
                if (idx_reg == IDX_W'(CLR_LEN - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    op_next    = req;
                    stat_next  = STAT_OK;
                    res_next   = 16'd0;
                    nino_next  = 9'd0;
                    chg_next   = 10'd0;
                    tally_next = '0;
                    idx_next   = IDX_W'(1);
                    pv_next    = 1'b0;
                    need_next  = NEED_W'(need_sum >> BYTE_SHIFT);
                    unique case (req.kind)
                        KIND_CREATE:
                        begin
                            state_next = S_C_SCAN;
                        end
                        KIND_EXTEND:
                        begin
                            if ((NEED_W'(need_sum >> BYTE_SHIFT) == '0) ||
                                (32'(req.cluster) < RESERVED_CLUSTERS) ||
                                (32'(req.cluster) >= TABLE_ENTRIES))
                            begin
                                state_next = S_DONE;
                            end
                            else
                            begin
                                state_next = S_E_CHK0;
                            end
                        end
                        KIND_RELEASE:
                        begin
                            if (32'(req.inode_number) >= INODE_MAX)
                            begin
                                stat_next  = STAT_NOTUSED;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                state_next = S_R_CHK;
                            end
                        end
                        KIND_READ:
                        begin
                            state_next = S_RD;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_C_SCAN:
            begin
                if (pv_reg && (tbl_rdata == 16'd0))
                begin
                    fc_next    = pa_reg;
                    row_next   = '0;
                    state_next = S_C_IA;
                end
                else if (scan_end)
                begin
                    stat_next  = STAT_NOSPACE;
                    state_next = S_DONE;
                end
            end
            S_C_IA:
            begin
                ino_raddr  = row_reg;
                state_next = S_C_IB;
            end
            S_C_IB:
            begin
                if (ino_rdata != 16'hffff)
                begin
                    rowd_next  = ino_rdata;
                    bit_next   = low_zero(ino_rdata);
                    state_next = S_C_WR;
                end
                else if (row_reg == ROW_AW'(MAP_ROWS - 1))
                begin
                    stat_next  = STAT_NOINODE;
                    state_next = S_DONE;
                end
                else
                begin
                    row_next   = row_reg + 1'b1;
                    state_next = S_C_IA;
                end
            end
            S_C_WR:
            begin
                tbl_we    = 1'b1;
                tbl_waddr = fc_reg;
                tbl_wdata = END_MARK;
                ino_we    = 1'b1;
                ino_waddr = row_reg;
                ino_wdata = rowd_reg | (16'd1 << bit_reg);
                if (fcnt_reg != '0)
                begin
                    fcnt_next = fcnt_reg - 1'b1;
                end
                if (icnt_reg != '0)
                begin
                    icnt_next = icnt_reg - 1'b1;
                end
                res_next   = 16'(fc_reg);
                nino_next  = 9'({row_reg, bit_reg});
                state_next = S_DONE;
            end
            S_E_CHK0:
            begin
                // A free start entry names no chain: nothing happens.
                if (tbl_rdata == 16'd0)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cur_next   = CL_AW'(op_reg.cluster);
                    v_next     = tbl_rdata;
                    state_next = S_E_CNT;
                end
            end
            S_E_CNT:
            begin
                if (pv_reg && (tbl_rdata == 16'd0))
                begin
                    tally_next = tally_reg + 1'b1;
                end
                else if (scan_end)
                begin
                    if ((fcnt_reg < CNT_W'(need_reg)) || (tally_reg < IDX_W'(need_reg)))
                    begin
                        stat_next  = STAT_NOSPACE;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        steps_next = '0;
                        state_next = S_E_WA;
                    end
                end
            end
            S_E_WA:
            begin
                if ((v_reg == END_MARK) || (v_reg < 16'(RESERVED_CLUSTERS)) ||
                    (32'(v_reg) >= TABLE_ENTRIES))
                begin
                    last_next  = cur_reg;
                    left_next  = need_reg;
                    idx_next   = IDX_W'(1);
                    pv_next    = 1'b0;
                    state_next = S_E_ALLOC;
                end
                else
                begin
                    tbl_raddr  = v_reg[CL_AW-1:0];
                    state_next = S_E_WB;
                end
            end
            S_E_WB:
            begin
                // The link target is free: the walk ends at the current cluster.
                if (tbl_rdata == 16'd0)
                begin
                    last_next  = cur_reg;
                    left_next  = need_reg;
                    idx_next   = IDX_W'(1);
                    pv_next    = 1'b0;
                    state_next = S_E_ALLOC;
                end
                else
                begin
                    cur_next   = v_reg[CL_AW-1:0];
                    v_next     = tbl_rdata;
                    steps_next = steps_reg + 1'b1;
                    if ((steps_reg + 1'b1) == IDX_W'(TABLE_ENTRIES))
                    begin
                        last_next  = v_reg[CL_AW-1:0];
                        left_next  = need_reg;
                        idx_next   = IDX_W'(1);
                        pv_next    = 1'b0;
                        state_next = S_E_ALLOC;
                    end
                    else
                    begin
                        state_next = S_E_WA;
                    end
                end
            end
            S_E_ALLOC:
            begin
                // Written entries lie behind the scan or were already in use,
                // so a stale read never turns a used entry into a free one.
                if (pv_reg && (tbl_rdata == 16'd0))
                begin
                    tbl_we    = 1'b1;
                    tbl_waddr = last_reg;
                    tbl_wdata = 16'(pa_reg);
                    last_next = pa_reg;
                    left_next = left_reg - 1'b1;
                    if (left_reg == NEED_W'(1))
                    begin
                        state_next = S_E_FIN;
                    end
                end
            end
            S_E_FIN:
            begin
                tbl_we     = 1'b1;
                tbl_waddr  = last_reg;
                tbl_wdata  = END_MARK;
                fcnt_next  = fcnt_reg - CNT_W'(need_reg);
                chg_next   = 10'(need_reg);
                state_next = S_DONE;
            end
            S_R_CHK:
            begin
                rowd_next = ino_rdata;
                row_next  = ROW_AW'(op_reg.inode_number >> 4);
                bit_next  = op_reg.inode_number[3:0];
                if (!ino_rdata[op_reg.inode_number[3:0]])
                begin
                    stat_next  = STAT_NOTUSED;
                    state_next = S_DONE;
                end
                else if ((32'(op_reg.cluster) >= RESERVED_CLUSTERS) &&
                         (32'(op_reg.cluster) < TABLE_ENTRIES))
                begin
                    cur_next   = CL_AW'(op_reg.cluster);
                    state_next = S_R_A;
                end
                else
                begin
                    state_next = S_R_FIN;
                end
            end
            S_R_A:
            begin
                tbl_raddr  = cur_reg;
                state_next = S_R_B;
            end
            S_R_B:
            begin
                if (tbl_rdata == 16'd0)
                begin
                    state_next = S_R_FIN;
                end
                else
                begin
                    tbl_we     = 1'b1;
                    tbl_waddr  = cur_reg;
                    tbl_wdata  = 16'd0;
                    tally_next = tally_reg + 1'b1;
                    if ((tbl_rdata == END_MARK) || (tbl_rdata < 16'(RESERVED_CLUSTERS)) ||
                        (32'(tbl_rdata) >= TABLE_ENTRIES))
                    begin
                        state_next = S_R_FIN;
                    end
                    else
                    begin
                        cur_next   = tbl_rdata[CL_AW-1:0];
                        state_next = S_R_A;
                    end
                end
            end
            S_R_FIN:
            begin
                if (fsum > (IDX_W + 1)'(CLUSTER_MAX))
                begin
                    fcnt_next = CNT_W'(CLUSTER_MAX);
                end
                else
                begin
                    fcnt_next = CNT_W'(fsum);
                end
                ino_we    = 1'b1;
                ino_waddr = row_reg;
                ino_wdata = rowd_reg & ~(16'd1 << bit_reg);
                if (32'(icnt_reg) < INODE_MAX)
                begin
                    icnt_next = icnt_reg + 1'b1;
                end
                chg_next   = 10'(tally_reg);
                state_next = S_DONE;
            end
            S_RD:
            begin
                if (32'(op_reg.cluster) < TABLE_ENTRIES)
                begin
                    res_next = tbl_rdata;
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_v_reg || !rsp_stall)
                begin
                    out_next.status           = stat_reg;
                    out_next.result_cluster   = res_reg;
                    out_next.new_inode        = nino_reg;
                    out_next.clusters_changed = chg_reg;
                    out_next.free_clusters    = fcnt_reg;
                    out_next.free_inodes      = icnt_reg;
                    out_v_next                = 1'b1;
                    state_next                = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            idx_reg   <= '0;
            pv_reg    <= 1'b0;
            fcnt_reg  <= CNT_W'(CLUSTER_MAX);
            icnt_reg  <= CNT_W'(INODE_MAX);
            out_v_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            pv_reg    <= pv_next;
            fcnt_reg  <= fcnt_next;
            icnt_reg  <= icnt_next;
            out_v_reg <= out_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        pa_reg    <= pa_next;
        cur_reg   <= cur_next;
        v_reg     <= v_next;
        steps_reg <= steps_next;
        last_reg  <= last_next;
        need_reg  <= need_next;
        left_reg  <= left_next;
        tally_reg <= tally_next;
        fc_reg    <= fc_next;
        row_reg   <= row_next;
        bit_reg   <= bit_next;
        rowd_reg  <= rowd_next;
        stat_reg  <= stat_next;
        res_reg   <= res_next;
        nino_reg  <= nino_next;
        chg_reg   <= chg_next;
        out_reg   <= out_next;
    end

    // Reserved clusters are written only by the clearing pass.
    `FCIA_ASSERT_IMPLY(a_reserved_kept, tbl_we && (state_reg != S_CLR), tbl_waddr >= CL_AW'(RESERVED_CLUSTERS), "write to a reserved cluster")
    // The free cluster count never rises above its reset value.
    `FCIA_ASSERT_IMPLY(a_fcnt_bound, 1'b1, fcnt_reg <= CNT_W'(CLUSTER_MAX), "free cluster count overflow")
    // An accepted item always starts work in the next cycle.
    `FCIA_ASSERT_NEXT(a_accept_busy, req_valid && !req_stall, state_reg != S_IDLE, "accepted item not started")

endmodule
